>>> hdl/rba_pkg.sv
// Package: item types, CORDIC constants and shared helpers for the rotated box bounds unit.
package rba_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CW = 34;  // CORDIC x/y datapath width
    localparam int ZW = 32;  // CORDIC angle width
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        half_x;
        logic [30:0]        half_y;
        logic [30:0]        half_z;
        logic [15:0]        yaw_angle;
        logic [15:0]        roll_angle;
        logic [15:0]        pitch_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
    } t_out_item;

    // CORDIC state handed from cell to cell, for both angles
    typedef struct packed {
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] ty;
        logic signed [ZW-1:0] tz;
        logic                 tq;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [ZW-1:0] pz;
        logic                 pq;
    } t_cordic;

    // box data that travels alongside the CORDIC chain
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        half_x;
        logic [30:0]        half_y;
        logic [30:0]        half_z;
    } t_box;

    function automatic logic signed [ZW-1:0] atan_turns(input logic [4:0] i);
        case (i)
            5'd0:    atan_turns = 32'sd536870912;
            5'd1:    atan_turns = 32'sd316933406;
            5'd2:    atan_turns = 32'sd167458907;
            5'd3:    atan_turns = 32'sd85004756;
            5'd4:    atan_turns = 32'sd42667331;
            5'd5:    atan_turns = 32'sd21354465;
            5'd6:    atan_turns = 32'sd10679838;
            5'd7:    atan_turns = 32'sd5340245;
            5'd8:    atan_turns = 32'sd2670163;
            5'd9:    atan_turns = 32'sd1335087;
            5'd10:   atan_turns = 32'sd667544;
            5'd11:   atan_turns = 32'sd333772;
            5'd12:   atan_turns = 32'sd166886;
            5'd13:   atan_turns = 32'sd83443;
            5'd14:   atan_turns = 32'sd41722;
            5'd15:   atan_turns = 32'sd20861;
            5'd16:   atan_turns = 32'sd10430;
            5'd17:   atan_turns = 32'sd5215;
            5'd18:   atan_turns = 32'sd2608;
            5'd19:   atan_turns = 32'sd1304;
            5'd20:   atan_turns = 32'sd652;
            5'd21:   atan_turns = 32'sd326;
            5'd22:   atan_turns = 32'sd163;
            5'd23:   atan_turns = 32'sd81;
            default: atan_turns = '0;
        endcase
    endfunction

    // |v| clamped to 1.0 in Q2.30
    function automatic logic [30:0] mag_clamp(input logic signed [CW-1:0] v);
        logic [CW-1:0] m;
        m = v[CW-1] ? CW'(-v) : CW'(v);
        mag_clamp = (m > CW'(Q30_ONE)) ? Q30_ONE : m[30:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            sat32 = 32'sh7fff_ffff;
        else if (v < -34'sd2147483648)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

>>> hdl/rba_cordic_cell.sv
// One CORDIC rotation cell: one micro-rotation on both angles, registered.
module rba_cordic_cell
    import rba_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_cordic i_c,
    input  t_box    i_box,
    output logic    o_vld,
    output t_cordic o_c,
    output t_box    o_box
);

    localparam logic signed [ZW-1:0] ATAN = atan_turns(5'(STEP));

    logic    r_vld;
    t_cordic r_c, n_c;
    t_box    r_box;

    always_comb begin
        n_c = i_c;
        // >>> on signed is floor shift
        if (!i_c.tz[ZW-1]) begin
            n_c.tx = i_c.tx - (i_c.ty >>> STEP);
            n_c.ty = i_c.ty + (i_c.tx >>> STEP);
            n_c.tz = i_c.tz - ATAN;
        end else begin
            n_c.tx = i_c.tx + (i_c.ty >>> STEP);
            n_c.ty = i_c.ty - (i_c.tx >>> STEP);
            n_c.tz = i_c.tz + ATAN;
        end
        if (!i_c.pz[ZW-1]) begin
            n_c.px = i_c.px - (i_c.py >>> STEP);
            n_c.py = i_c.py + (i_c.px >>> STEP);
            n_c.pz = i_c.pz - ATAN;
        end else begin
            n_c.px = i_c.px + (i_c.py >>> STEP);
            n_c.py = i_c.py - (i_c.px >>> STEP);
            n_c.pz = i_c.pz + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_c   <= n_c;
        r_box <= i_box;
    end

    assign o_vld = r_vld;
    assign o_c   = r_c;
    assign o_box = r_box;

endmodule

>>> hdl/rba_bounds.sv
// Back end: matrix entries, half-widths and saturated bounds, pipelined.
module rba_bounds
    import rba_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_vld,
    input  t_cordic   i_c,
    input  t_box      i_box,
    output logic      o_vld,
    output t_out_item o_item
);

    logic [30:0] ct, st, cp, sp;
    always_comb begin
        ct = i_c.tq ? mag_clamp(i_c.ty) : mag_clamp(i_c.tx);
        st = i_c.tq ? mag_clamp(i_c.tx) : mag_clamp(i_c.ty);
        cp = i_c.pq ? mag_clamp(i_c.py) : mag_clamp(i_c.px);
        sp = i_c.pq ? mag_clamp(i_c.px) : mag_clamp(i_c.py);
    end

    // stage 1: products of magnitudes
    logic [2:0]  r_vld;
    logic [61:0] r_p0, r_p1, r_p2, r_p3;
    logic [30:0] r_st1, r_ct1, r_cp1, r_sp1;
    t_box        r_box1, r_box2, r_box3;
    // stage 2: rounded entries
    logic [30:0] r_m00, r_m02, r_m10, r_m12, r_st2, r_ct2, r_sp2, r_cp2;
    // stage 3: entry*half products
    logic [61:0] r_q [9];
    // stage 4: output
    t_out_item   r_out;
    logic        r_ovld;

    logic [63:0] w0, w1, w2;
    logic [32:0] hw0, hw1, hw2;
    always_comb begin
        w0  = 64'(r_q[0]) + 64'(r_q[1]) + 64'(r_q[2]) + 64'd536870912;
        w1  = 64'(r_q[3]) + 64'(r_q[4]) + 64'(r_q[5]) + 64'd536870912;
        w2  = 64'(r_q[6]) + 64'(r_q[8]) + 64'd536870912;
        hw0 = w0[62:30];
        hw1 = w1[62:30];
        hw2 = w2[62:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_vld  <= {r_vld[1:0], i_vld};
            r_ovld <= r_vld[2];
        end
        r_p0  <= ct * cp;
        r_p1  <= ct * sp;
        r_p2  <= st * cp;
        r_p3  <= st * sp;
        r_st1 <= st;
        r_ct1 <= ct;
        r_cp1 <= cp;
        r_sp1 <= sp;
        r_box1 <= i_box;

        r_m00 <= 31'((r_p0 + 62'd536870912) >> 30);
        r_m02 <= 31'((r_p1 + 62'd536870912) >> 30);
        r_m10 <= 31'((r_p2 + 62'd536870912) >> 30);
        r_m12 <= 31'((r_p3 + 62'd536870912) >> 30);
        r_st2 <= r_st1;
        r_ct2 <= r_ct1;
        r_cp2 <= r_cp1;
        r_sp2 <= r_sp1;
        r_box2 <= r_box1;

        r_q[0] <= r_m00 * r_box2.half_x;
        r_q[1] <= r_st2 * r_box2.half_y;
        r_q[2] <= r_m02 * r_box2.half_z;
        r_q[3] <= r_m10 * r_box2.half_x;
        r_q[4] <= r_ct2 * r_box2.half_y;
        r_q[5] <= r_m12 * r_box2.half_z;
        r_q[6] <= r_sp2 * r_box2.half_x;
        r_q[7] <= '0;
        r_q[8] <= r_cp2 * r_box2.half_z;
        r_box3 <= r_box2;

        r_out.min_x <= sat32(34'(r_box3.center_x) - 34'(hw0));
        r_out.min_y <= sat32(34'(r_box3.center_y) - 34'(hw1));
        r_out.min_z <= sat32(34'(r_box3.center_z) - 34'(hw2));
        r_out.max_x <= sat32(34'(r_box3.center_x) + 34'(hw0));
        r_out.max_y <= sat32(34'(r_box3.center_y) + 34'(hw1));
        r_out.max_z <= sat32(34'(r_box3.center_z) + 34'(hw2));
    end

    assign o_vld  = r_ovld;
    assign o_item = r_out;

    // a result never appears without an earlier item on the input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> $past(i_vld, 4))
        else $error("bounds result without item");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (o_item.min_x <= o_item.max_x) && (o_item.min_y <= o_item.max_y)
                  && (o_item.min_z <= o_item.max_z))
        else $error("bounds min above max");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_st1 <= Q30_ONE) && (r_ct1 <= Q30_ONE))
        else $error("trig magnitude above one");

endmodule

>>> hdl/rotated_box_aabb_unit.sv
// Top level: rotated box to axis-aligned bounds, CORDIC cell chain plus bounds pipeline.
//
// Takes one box per clock: whenever busy is low (it always is once out of reset) a
// start pulse accepts the item on i_item. Each item gives one result on o_item,
// flagged by a one-cycle o_done strobe. Each item passes through one
// input register, 24 CORDIC cells (one micro-rotation each, yaw+roll and pitch
// done side by side), then four bound stages (magnitude products, rounding,
// extent products, sum and saturate). The receiver cannot stall; results come
// out in order at the same rate the items went in. No state is kept between items.
module rotated_box_aabb_unit
    import rba_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_item
);

    logic [15:0] theta;
    t_cordic     n_c0;
    t_box        n_box0;
    logic        r_vld0;
    t_cordic     r_c0;
    t_box        r_box0;

    assign busy = 1'b0;

    always_comb begin
        // yaw and roll both turn about z; binary angles simply add
        theta   = i_item.yaw_angle + i_item.roll_angle;
        n_c0.tx = CORDIC_GAIN;
        n_c0.ty = '0;
        n_c0.tz = ZW'({theta[13:0], 16'h0000});
        n_c0.tq = theta[14];
        n_c0.px = CORDIC_GAIN;
        n_c0.py = '0;
        n_c0.pz = ZW'({i_item.pitch_angle[13:0], 16'h0000});
        n_c0.pq = i_item.pitch_angle[14];
        n_box0.center_x = i_item.center_x;
        n_box0.center_y = i_item.center_y;
        n_box0.center_z = i_item.center_z;
        n_box0.half_x   = i_item.half_x;
        n_box0.half_y   = i_item.half_y;
        n_box0.half_z   = i_item.half_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= start && !busy;
        end
        r_c0   <= n_c0;
        r_box0 <= n_box0;
    end

    // CORDIC chain
    logic    vld [CORDIC_STEPS+1];
    t_cordic cc  [CORDIC_STEPS+1];
    t_box    bx  [CORDIC_STEPS+1];

    assign vld[0] = r_vld0;
    assign cc[0]  = r_c0;
    assign bx[0]  = r_box0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        rba_cordic_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (vld[g]),
            .i_c     (cc[g]),
            .i_box   (bx[g]),
            .o_vld   (vld[g+1]),
            .o_c     (cc[g+1]),
            .o_box   (bx[g+1])
        );
    end

    rba_bounds u_bounds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld[CORDIC_STEPS]),
        .i_c     (cc[CORDIC_STEPS]),
        .i_box   (bx[CORDIC_STEPS]),
        .o_vld   (o_done),
        .o_item  (o_item)
    );

    // every accepted item comes out as a result, and nothing else does
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 29))
        else $error("result without item");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(start, 29) && $past(i_rst_n, 29) && $past(i_rst_n, 1) |-> o_done)
        else $error("item lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld0 |-> r_c0.ty == '0)
        else $error("cordic seed wrong");

endmodule

>>> bench/testbench.sv
// Testbench for the rotated box bounds unit: directed table plus random boxes.
module testbench;
    import rba_pkg::*;

    // Command-style handshake on the input side: an item is taken at a rising edge
    // where start is high and busy is low. Results come back as one-cycle o_done
    // strobes and can't be held off, so only the sender side idles at random.

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_done;
    t_out_item o_item;

    rotated_box_aabb_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_item  (o_item)
    );

    // bounds still owed by the block, oldest first
    t_out_item bounds_due[$];
    int        mismatches;
    int        boxes_sent;
    int        bounds_seen;
    int        n_directed;
    int        n_random;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Limit: room for the directed rows and 1800 random items, many times over.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Bounds predictor
    // ---------------------------------------------------------------------

    // Arithmetic right shift, rounding toward minus infinity.
    function automatic longint floor_shr(input longint v, input int s);
        floor_shr = v >>> s;
    endfunction

    // Magnitudes of cos and sin of a binary angle, Q2.30; fixed CORDIC chain.
    function automatic void sincos_mag(input logic [15:0] ang,
                                       output longint unsigned cm,
                                       output longint unsigned sm);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint ax;
        longint ay;
        longint step_ang [24];
        step_ang = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                     10679838, 5340245, 2670163, 1335087, 667544, 333772,
                     166886, 83443, 41722, 20861, 10430, 5215,
                     2608, 1304, 652, 326, 163, 81};
        x = 652032874;
        y = 0;
        z = longint'({ang[13:0], 16'h0000});
        for (int i = 0; i < 24; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= step_ang[i];
            end else begin
                x += dx; y -= dy; z += step_ang[i];
            end
        end
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        if (ax > 64'sd1073741824) ax = 64'sd1073741824;
        if (ay > 64'sd1073741824) ay = 64'sd1073741824;
        // odd quadrants trade sine for cosine
        if (ang[14]) begin
            cm = ay; sm = ax;
        end else begin
            cm = ax; sm = ay;
        end
    endfunction

    function automatic longint unsigned q30_mul(input longint unsigned a,
                                                input longint unsigned b);
        q30_mul = (a * b + 64'd536870912) >> 30;
    endfunction

    function automatic longint unsigned extent_along(
            input longint unsigned c0, input longint unsigned c1,
            input longint unsigned c2, input t_in_item b);
        extent_along = (c0 * b.half_x + c1 * b.half_y + c2 * b.half_z
                        + 64'd536870912) >> 30;
    endfunction

    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647)
            clamp_q16 = 32'sh7fff_ffff;
        else if (v < -64'sd2147483648)
            clamp_q16 = 32'sh8000_0000;
        else
            clamp_q16 = v[31:0];
    endfunction

    function automatic t_out_item box_bounds(input t_in_item b);
        longint unsigned ct, st, cp, sp;
        longint unsigned wx, wy, wz;
        logic [15:0]     theta;
        t_out_item       r;
        // two turns about z collapse to one; mod 2^16 is exact for binary angles
        theta = b.yaw_angle + b.roll_angle;
        sincos_mag(theta, ct, st);
        sincos_mag(b.pitch_angle, cp, sp);
        wx = extent_along(q30_mul(ct, cp), st, q30_mul(ct, sp), b);
        wy = extent_along(q30_mul(st, cp), ct, q30_mul(st, sp), b);
        wz = extent_along(sp, 0, cp, b);
        r.min_x = clamp_q16(longint'(b.center_x) - longint'(wx));
        r.min_y = clamp_q16(longint'(b.center_y) - longint'(wy));
        r.min_z = clamp_q16(longint'(b.center_z) - longint'(wz));
        r.max_x = clamp_q16(longint'(b.center_x) + longint'(wx));
        r.max_y = clamp_q16(longint'(b.center_y) + longint'(wy));
        r.max_z = clamp_q16(longint'(b.center_z) + longint'(wz));
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Result checker: every strobe is matched against the oldest prediction
    // ---------------------------------------------------------------------
    task automatic report_field(input string fname, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on bounds %0d, %s: expected %h, got %h",
                         bounds_seen, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (bounds_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected bounds strobe, nothing outstanding");
            end else begin
                want = bounds_due.pop_front();
                report_field("min_x", want.min_x, o_item.min_x);
                report_field("min_y", want.min_y, o_item.min_y);
                report_field("min_z", want.min_z, o_item.min_z);
                report_field("max_x", want.max_x, o_item.max_x);
                report_field("max_y", want.max_y, o_item.max_y);
                report_field("max_z", want.max_z, o_item.max_z);
            end
            bounds_seen++;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    // Directed rows. has_want marks rows whose bounds are plain to see;
    // the rest go through the predictor.
    typedef struct {
        t_in_item  box;
        bit        has_want;
        t_out_item want;
    } t_row;

    t_row plan[$];

    function automatic t_in_item mk_box(
            input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
            input logic [30:0] hx, input logic [30:0] hy, input logic [30:0] hz,
            input logic [15:0] yaw, input logic [15:0] roll, input logic [15:0] pitch);
        t_in_item b;
        b.center_x = cx; b.center_y = cy; b.center_z = cz;
        b.half_x = hx; b.half_y = hy; b.half_z = hz;
        b.yaw_angle = yaw; b.roll_angle = roll; b.pitch_angle = pitch;
        return b;
    endfunction

    task automatic add_row(input t_in_item b);
        t_row r;
        r.box = b;
        r.has_want = 1'b0;
        r.want = '0;
        plan.push_back(r);
    endtask

    // degenerate box: zero extents, bounds collapse onto the center
    task automatic add_point_row(input t_in_item b);
        t_row r;
        r.box = b;
        r.has_want = 1'b1;
        r.want = '{b.center_x, b.center_y, b.center_z,
                   b.center_x, b.center_y, b.center_z};
        plan.push_back(r);
    endtask

    // Random box; about a third small extents near the origin, a few extremes.
    function automatic t_in_item rand_box();
        t_in_item b;
        b = t_in_item'({$urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                b.center_x = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
                b.center_y = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
                b.center_z = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
                b.half_x = 31'($urandom_range(0, 32'h003f_ffff));
                b.half_y = 31'($urandom_range(0, 32'h003f_ffff));
                b.half_z = 31'($urandom_range(0, 32'h003f_ffff));
            end
            3: begin
                // angles on and next to quadrant edges
                b.yaw_angle = {2'($urandom_range(0, 3)), 14'h0}
                              + 16'($urandom_range(0, 2)) - 16'd1;
                b.pitch_angle = {2'($urandom_range(0, 3)), 14'h0}
                                + 16'($urandom_range(0, 2)) - 16'd1;
            end
            4: begin
                b.half_x = $urandom_range(0, 1) ? 31'h7fff_ffff : 31'h0;
                b.half_y = $urandom_range(0, 1) ? 31'h7fff_ffff : 31'h0;
                b.half_z = $urandom_range(0, 1) ? 31'h7fff_ffff : 31'h0;
            end
            default: ;
        endcase
        return b;
    endfunction

    // One item: optional random idle, then hold start until it is taken.
    task automatic send_box(input t_in_item b, input t_out_item want, input bit idle_ok);
        while (idle_ok && $urandom_range(0, 99) < 12) begin
            start <= 1'b0;
            i_item <= t_in_item'({$urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom, $urandom});
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // accepted at this edge
        bounds_due.push_back(want);
        boxes_sent++;
        @(negedge i_clk);
    endtask

    initial begin
        t_in_item b;
        int       waited;
        mismatches  = 0;
        boxes_sent  = 0;
        bounds_seen = 0;
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part: extremes of every field, zero extents, quadrant edges
        add_point_row(mk_box(32'h0, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0, 16'h0, 16'h0, 16'h0));
        add_point_row(mk_box(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                             31'h0, 31'h0, 31'h0, 16'hffff, 16'h1234, 16'hffff));
        add_point_row(mk_box(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                             31'h0, 31'h0, 31'h0, 16'h8000, 16'h8000, 16'h4000));
        // saturation both ways with the largest extents
        add_row(mk_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                       31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 16'h0, 16'h0, 16'h0));
        add_row(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 16'h2000, 16'h0, 16'h2000));
        add_row(mk_box(32'h8000_0000, 32'h7fff_ffff, 32'h0,
                       31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff,
                       16'hffff, 16'hffff, 16'hffff));
        // each quadrant edge on yaw, roll and pitch, box with unequal half extents
        for (int q = 0; q < 4; q++) begin
            add_row(mk_box(32'h0, 32'h0, 32'h0, 31'h0001_0000, 31'h0002_0000,
                           31'h0003_0000, 16'(q << 14), 16'h0, 16'h0));
            add_row(mk_box(32'h0001_0000, 32'h0, 32'hffff_0000, 31'h0001_0000,
                           31'h0002_0000, 31'h0003_0000, 16'h0, 16'(q << 14), 16'(q << 14)));
        end
        // yaw plus roll wraps past a full turn
        add_row(mk_box(32'h0, 32'h0, 32'h0, 31'h0001_0000, 31'h0001_0000,
                       31'h0001_0000, 16'hc000, 16'h6000, 16'h2000));
        add_row(mk_box(32'h1234_5678, 32'hedcb_a988, 32'h0, 31'h5555_5555,
                       31'h2aaa_aaaa, 31'h0000_0001, 16'h3fff, 16'h0001, 16'hbfff));
        add_row(mk_box(32'h0, 32'h0, 32'h0, 31'h0000_0001, 31'h0, 31'h7fff_ffff,
                       16'h1555, 16'h2aaa, 16'h7fff));

        foreach (plan[i]) begin
            if (plan[i].has_want && box_bounds(plan[i].box) !== plan[i].want)
                $display("directed row %0d: predictor disagrees with table", i);
            send_box(plan[i].box,
                     plan[i].has_want ? plan[i].want : box_bounds(plan[i].box), 1'b0);
        end
        n_directed = plan.size();

        // random part; items 600..899 go without any idle to stream at full rate
        n_random = 1800;
        for (int n = 0; n < n_random; n++) begin
            b = rand_box();
            send_box(b, box_bounds(b), !(n >= 600 && n < 900));
        end
        start  <= 1'b0;
        i_item <= '0;

        // drain: wait until no bounds are owed or the wait limit runs out
        waited = 0;
        while (bounds_due.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);

        if (bounds_due.size() != 0) begin
            mismatches++;
            $display("%0d bounds never arrived", bounds_due.size());
        end

        $display("%0d boxes sent (%0d directed, %0d random), %0d bounds checked",
                 boxes_sent, n_directed, n_random, bounds_seen);
        $display("%0d field mismatches", mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> rotated_box_aabb_unit.f
hdl/rba_pkg.sv
hdl/rba_cordic_cell.sv
hdl/rba_bounds.sv
hdl/rotated_box_aabb_unit.sv
bench/testbench.sv
